[hdl/gpb_pkg.sv]
// ----------------------------------------------------------------------------
// gpb_pkg
// Shared types and constants for the global progress binder.
// ----------------------------------------------------------------------------
package gpb_pkg;

    // Field widths of the request and result channels
    localparam int OP_W       = 2;
    localparam int ID_W       = 6;
    localparam int COUNT_W    = 48;
    localparam int EXPECTED_W = 6;

    // Width used to compare populations against the expected count
    localparam int POP_CMP_W = 7;

    // Default population and reset value of the expected count
    localparam int SOURCE_COUNT_DEF = 32;
    localparam logic [EXPECTED_W-1:0] EXPECTED_RESET = 6'd32;

    // Request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_REGISTER = 2'd0,
        OP_PROGRESS = 2'd1,
        OP_TICK     = 2'd2
    } op_t;

    // Result kinds and status codes
    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_BIND    = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROG,
        ST_RD,
        ST_EVAL,
        ST_FLUSH
    } state_t;

endpackage

[hdl/gpb_ram.sv]
// ----------------------------------------------------------------------------
// gpb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gpb_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds its data while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/global_progress_binder_unit.sv]
// A register request gives its result in the output register in the cycle after
// acceptance; a progress request passes through the read in idle and then ST_PROG (compare, write).
// One register request is taken per cycle while the output is not stalled; a progress request
// holds off new requests until its compare and write are done. A ready tick scans every source
// entry with a read then an evaluate step each over the two progress memories, and waits on output stalls.
// Reset clears all maps, population counters and the output valid flag, and sets expected to 32.
// ----------------------------------------------------------------------------
// global_progress_binder_unit
// Per-source progress sequencer: registration, progress reports and binding
// ticks over a table of reported and bound counts held in two RAMs.
// ----------------------------------------------------------------------------
module global_progress_binder_unit #(
    parameter int SOURCE_COUNT = gpb_pkg::SOURCE_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           config_write,
    input  logic [gpb_pkg::EXPECTED_W-1:0] config_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [gpb_pkg::OP_W-1:0]       op,
    input  logic [gpb_pkg::ID_W-1:0]       source_id,
    input  logic [gpb_pkg::COUNT_W-1:0]    progress_count,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           kind,
    output logic                           status,
    output logic [gpb_pkg::ID_W-1:0]       bound_source,
    output logic [gpb_pkg::COUNT_W-1:0]    bind_count,
    output logic                           last
);

    import gpb_pkg::*;

    localparam int IDX_W = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
    localparam int CNT_W = $clog2(SOURCE_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SOURCE_COUNT - 1);
    localparam logic [POP_CMP_W-1:0] SRC_LIMIT = POP_CMP_W'(SOURCE_COUNT);

    // Control state
    state_t                  state_reg, state_next;
    logic [EXPECTED_W-1:0]   expected_reg;
    logic [SOURCE_COUNT-1:0] reg_map_reg, reg_map_next;
    logic [SOURCE_COUNT-1:0] rep_map_reg, rep_map_next;
    logic [SOURCE_COUNT-1:0] bnd_valid_reg, bnd_valid_next;
    logic [CNT_W-1:0]        reg_cnt_reg, reg_cnt_next;
    logic [CNT_W-1:0]        rep_cnt_reg, rep_cnt_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic                    out_valid_reg, out_valid_next;

    // Payload registers
    logic [IDX_W-1:0]   pidx_reg, pidx_next;
    logic [COUNT_W-1:0] pcnt_reg, pcnt_next;
    logic [ID_W-1:0]    pend_src_reg, pend_src_next;
    logic [COUNT_W-1:0] pend_cnt_reg, pend_cnt_next;
    logic               kind_reg, kind_next;
    logic               status_reg, status_next;
    logic [ID_W-1:0]    src_reg, src_next;
    logic [COUNT_W-1:0] bind_reg, bind_next;
    logic               last_reg, last_next;

    // Memory ports
    logic               rep_wr_en, rep_rd_en, bnd_wr_en, bnd_rd_en;
    logic [IDX_W-1:0]   rep_wr_addr, rep_rd_addr;
    logic [COUNT_W-1:0] rep_wr_data, rep_rdata, bnd_rdata;

    // Request decode
    logic             in_accept, out_free, id_ok, tick_ready;
    logic [IDX_W-1:0] in_idx;
    logic [COUNT_W-1:0] rep_eff, bnd_eff, delta;
    logic             hit;

    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = !((state_reg == ST_IDLE) && out_free);
    assign in_accept  = in_valid && !in_stall;
    assign id_ok      = POP_CMP_W'(source_id) < SRC_LIMIT;
    assign in_idx     = source_id[IDX_W-1:0];
    assign tick_ready = (POP_CMP_W'(reg_cnt_reg) >= POP_CMP_W'(expected_reg))
                     && (POP_CMP_W'(rep_cnt_reg) >= POP_CMP_W'(expected_reg));

    // Effective table entries: unwritten entries read as zero
    assign rep_eff = rep_map_reg[idx_reg] ? rep_rdata : '0;
    assign bnd_eff = bnd_valid_reg[idx_reg] ? bnd_rdata : '0;
    assign hit     = reg_map_reg[idx_reg] && (rep_eff > bnd_eff);
    assign delta   = rep_eff - bnd_eff;

    // Reported and bound count tables
    gpb_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (SOURCE_COUNT)
    ) u_rep_ram (
        .clk     (clk),
        .wr_en   (rep_wr_en),
        .wr_addr (rep_wr_addr),
        .wr_data (rep_wr_data),
        .rd_en   (rep_rd_en),
        .rd_addr (rep_rd_addr),
        .rd_data (rep_rdata)
    );

    gpb_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (SOURCE_COUNT)
    ) u_bnd_ram (
        .clk     (clk),
        .wr_en   (bnd_wr_en),
        .wr_addr (idx_reg),
        .wr_data (rep_eff),
        .rd_en   (bnd_rd_en),
        .rd_addr (idx_reg),
        .rd_data (bnd_rdata)
    );

    // Next state, table updates and result pushes
    always_comb
    begin
        state_next      = state_reg;
        reg_map_next    = reg_map_reg;
        rep_map_next    = rep_map_reg;
        bnd_valid_next  = bnd_valid_reg;
        reg_cnt_next    = reg_cnt_reg;
        rep_cnt_next    = rep_cnt_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pidx_next       = pidx_reg;
        pcnt_next       = pcnt_reg;
        pend_src_next   = pend_src_reg;
        pend_cnt_next   = pend_cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        kind_next       = kind_reg;
        status_next     = status_reg;
        src_next        = src_reg;
        bind_next       = bind_reg;
        last_next       = last_reg;
        rep_wr_en       = 1'b0;
        rep_wr_addr     = pidx_reg;
        rep_wr_data     = pcnt_reg;
        rep_rd_en       = 1'b0;
        rep_rd_addr     = idx_reg;
        bnd_wr_en       = 1'b0;
        bnd_rd_en       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (op_t'(op))
                        OP_REGISTER:
                        begin
                            if (id_ok && !reg_map_reg[in_idx])
                            begin
                                reg_map_next[in_idx] = 1'b1;
                                reg_cnt_next         = reg_cnt_reg + CNT_W'(1);
                            end
                            out_valid_next = 1'b1;
                            kind_next      = KIND_ACK;
                            status_next    = id_ok ? STATUS_OK : STATUS_RANGE;
                            src_next       = source_id;
                            bind_next      = '0;
                            last_next      = 1'b1;
                        end
                        OP_PROGRESS:
                        begin
                            // Fetch the stored count, compare next cycle
                            if (id_ok)
                            begin
                                rep_rd_en   = 1'b1;
                                rep_rd_addr = in_idx;
                                pidx_next   = in_idx;
                                pcnt_next   = progress_count;
                                state_next  = ST_PROG;
                            end
                        end
                        OP_TICK:
                        begin
                            if (tick_ready)
                            begin
                                idx_next   = '0;
                                state_next = ST_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_PROG:
            begin
                // Raise the reported count unless it would go down
                if (pcnt_reg >= (rep_map_reg[pidx_reg] ? rep_rdata : '0))
                begin
                    rep_wr_en = 1'b1;
                    if (!rep_map_reg[pidx_reg])
                    begin
                        rep_map_next[pidx_reg] = 1'b1;
                        rep_cnt_next           = rep_cnt_reg + CNT_W'(1);
                    end
                end
                state_next = ST_IDLE;
            end

            ST_RD:
            begin
                rep_rd_en  = 1'b1;
                bnd_rd_en  = 1'b1;
                state_next = ST_EVAL;
            end

            ST_EVAL:
            begin
                // Hold while a pending entry cannot be pushed out
                if (!hit || !pend_valid_reg || out_free)
                begin
                    if (hit)
                    begin
                        bnd_wr_en               = 1'b1;
                        bnd_valid_next[idx_reg] = 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_BIND;
                            status_next    = STATUS_OK;
                            src_next       = pend_src_reg;
                            bind_next      = pend_cnt_reg;
                            last_next      = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_src_next   = ID_W'(idx_reg);
                        pend_cnt_next   = delta;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_RD;
                    end
                end
            end

            ST_FLUSH:
            begin
                // Drain the held entry as the final result of the tick
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    kind_next       = KIND_BIND;
                    status_next     = STATUS_OK;
                    src_next        = pend_src_reg;
                    bind_next       = pend_cnt_reg;
                    last_next       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            expected_reg   <= EXPECTED_RESET;
            reg_map_reg    <= '0;
            rep_map_reg    <= '0;
            bnd_valid_reg  <= '0;
            reg_cnt_reg    <= '0;
            rep_cnt_reg    <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            reg_map_reg    <= reg_map_next;
            rep_map_reg    <= rep_map_next;
            bnd_valid_reg  <= bnd_valid_next;
            reg_cnt_reg    <= reg_cnt_next;
            rep_cnt_reg    <= rep_cnt_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (config_write)
            begin
                expected_reg <= config_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pidx_reg     <= pidx_next;
        pcnt_reg     <= pcnt_next;
        pend_src_reg <= pend_src_next;
        pend_cnt_reg <= pend_cnt_next;
        kind_reg     <= kind_next;
        status_reg   <= status_next;
        src_reg      <= src_next;
        bind_reg     <= bind_next;
        last_reg     <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign status       = status_reg;
    assign bound_source = src_reg;
    assign bind_count   = bind_reg;
    assign last         = last_reg;

    // Population counters track their maps
    a_reg_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        32'(reg_cnt_reg) == $countones(reg_map_reg))
        else $error("registered population counter out of step with map");

    a_rep_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        32'(rep_cnt_reg) == $countones(rep_map_reg))
        else $error("reported population counter out of step with map");

    // A bound entry only exists for a source that has reported
    a_bnd_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (bnd_valid_reg & ~rep_map_reg) == '0)
        else $error("bound entry without reported entry");

    // Binding entries never carry a zero amount
    a_bind_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_BIND)) |-> (bind_reg != '0))
        else $error("binding entry with zero amount");

    // No held entry survives outside a tick scan
    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending binding entry left after scan");

endmodule
